FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/hwsc_pkg.sv
// types and constants of the helicity window sequence checker
// no dependencies; imported by the tracker and the top level
`timescale 1ns / 1ps

package hwsc_pkg;

	// default time slot width
	localparam int SLOT_BITS_DEF = 8;

	// window position: 0..3 when synchronized, this value before the first multiplet start
	localparam logic [2:0] POS_UNSYNC = 3'd5;

	// error codes
	typedef logic [3:0] err_code_t;
	localparam err_code_t ERR_OK          = 4'd0;
	localparam err_code_t ERR_PS_MID      = 4'd1;
	localparam err_code_t ERR_PS_SAME     = 4'd2;
	localparam err_code_t ERR_HEL_MID     = 4'd3;
	localparam err_code_t ERR_HEL_SAME    = 4'd4;
	localparam err_code_t ERR_HEL_WRONG   = 4'd5;
	localparam err_code_t ERR_HEL_CHANGED = 4'd6;
	localparam err_code_t ERR_UNEXP_FIRST = 4'd7;
	localparam err_code_t ERR_UNEXP_OTHER = 4'd8;
	localparam err_code_t ERR_MS_MID      = 4'd9;
	localparam err_code_t ERR_PS_POS      = 4'd10;

	// sync, helicity and prediction bits of one event
	typedef struct packed {
		logic hel;
		logic ps;
		logic ms;
		logic pred_ok;
	} event_bits_t;

	// bits kept from the first event of a window
	typedef struct packed {
		logic ms;
		logic ps;
		logic hel;
	} win_bits_t;

endpackage

FILE: rtl/hwsc_tracker.sv
// window tracking state and the per-event checks
// depends on hwsc_pkg
`timescale 1ns / 1ps

module hwsc_tracker import hwsc_pkg::*; #(
	parameter int SLOT_BITS = SLOT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 enable,
	input  logic [SLOT_BITS-1:0] slot,
	input  event_bits_t          ev,
	output err_code_t            code
);

	logic [SLOT_BITS-1:0] prev_slot_q;
	logic [2:0]           pos_q, pos_n;
	logic                 cur_valid_q, cur_valid_n;
	logic                 prev_valid_q, prev_valid_n;
	win_bits_t            cur_bits_q, cur_bits_n;
	win_bits_t            prev_bits_q, prev_bits_n;
	logic                 new_win;
	logic [1:0]           pos_adv;

	// window boundary detection and checks, last failing check wins
	always_comb begin
		new_win = (slot == SLOT_BITS'(1)) || (slot <= prev_slot_q);
		pos_adv = pos_q[1:0] + 2'd1;
		pos_n = pos_q;
		cur_valid_n = cur_valid_q;
		cur_bits_n = cur_bits_q;
		prev_valid_n = prev_valid_q;
		prev_bits_n = prev_bits_q;
		code = ERR_OK;
		if (new_win) begin
			prev_valid_n = cur_valid_q;
			prev_bits_n = cur_bits_q;
			cur_valid_n = 1'b1;
			cur_bits_n = '{ms: ev.ms, ps: ev.ps, hel: ev.hel};
			// multiplet position
			if (!ev.ms && pos_q == POS_UNSYNC) begin
				pos_n = 3'd0;
			end else if (pos_q < POS_UNSYNC) begin
				pos_n = {1'b0, pos_adv};
				if (!ev.ms && pos_adv != 2'd0) begin
					code = ERR_UNEXP_FIRST;
					pos_n = 3'd0;
				end else if (ev.ms && pos_adv == 2'd0) begin
					code = ERR_UNEXP_OTHER;
				end
			end
			// predictor at multiplet start
			if (pos_n == 3'd0 && !ev.pred_ok) begin
				code = ERR_HEL_WRONG;
			end
			// pair sync against position
			if (((pos_n == 3'd0 || pos_n == 3'd2) && ev.ps) ||
			    ((pos_n == 3'd1 || pos_n == 3'd3) && !ev.ps)) begin
				code = ERR_PS_POS;
			end
			// against the previous window
			if (cur_valid_q) begin
				if (ev.ps == cur_bits_q.ps) begin
					code = ERR_PS_SAME;
				end
				if (pos_n == 3'd1 || pos_n == 3'd3) begin
					if (ev.hel == cur_bits_q.hel) begin
						code = ERR_HEL_SAME;
					end
				end else if (pos_n == 3'd2) begin
					if (ev.hel != cur_bits_q.hel) begin
						code = ERR_HEL_CHANGED;
					end
				end
			end
		end else if (cur_valid_q) begin
			// inside a window, against its first event
			if (ev.ps != cur_bits_q.ps) begin
				code = ERR_PS_MID;
			end
			if (ev.ms != cur_bits_q.ms) begin
				code = ERR_MS_MID;
			end
			if (ev.hel != cur_bits_q.hel) begin
				code = ERR_HEL_MID;
			end
		end
	end

	// slot history follows every event, window state only while checking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_slot_q <= '0;
			pos_q <= POS_UNSYNC;
			cur_valid_q <= 1'b0;
			prev_valid_q <= 1'b0;
			cur_bits_q <= '0;
			prev_bits_q <= '0;
		end else if (fire) begin
			prev_slot_q <= slot;
			if (enable) begin
				pos_q <= pos_n;
				cur_valid_q <= cur_valid_n;
				prev_valid_q <= prev_valid_n;
				cur_bits_q <= cur_bits_n;
				prev_bits_q <= prev_bits_n;
			end
		end
	end

endmodule

FILE: rtl/helicity_window_sequence_checker.sv
// top level of the helicity window sequence checker: input stage, config, result register
// depends on hwsc_pkg and hwsc_tracker
//
//  channel   handshake                  payload
//  event     event_valid / event_ready  time_slot, helicity, pair_sync, multiplet_sync,
//                                       helicity_predicted_ok
//  result    result_valid/result_ready  error_code
//  config    cfg_valid / cfg_ready      check_enabled
//
// one event per cycle unless a result stalls; event stage, then result register
// the window state loop (position, slot and window bits) closes within the tracker
// reset clears the control and window state: position unsynchronised, checks enabled
// a stalled result holds the event stage; the event stage still refills as the result drains
// while checks are disabled events pass through with no result
`timescale 1ns / 1ps

module helicity_window_sequence_checker import hwsc_pkg::*; #(
	parameter int SLOT_BITS = SLOT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 event_valid,
	output logic                 event_ready,
	input  logic [SLOT_BITS-1:0] time_slot,
	input  logic                 helicity,
	input  logic                 pair_sync,
	input  logic                 multiplet_sync,
	input  logic                 helicity_predicted_ok,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [3:0]           error_code,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 check_enabled
);

	logic                 check_enabled_q;
	logic                 valid_s1;
	logic [SLOT_BITS-1:0] slot_s1;
	event_bits_t          ev_s1;
	logic                 fire;
	err_code_t            code;
	logic                 out_valid_q;
	err_code_t            out_code_q;

	// config register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enabled_q <= 1'b1;
		end else if (cfg_valid) begin
			check_enabled_q <= check_enabled;
		end
	end

	// event stage moves on when checks are off or the result register can take its request
	assign fire = valid_s1 && (!check_enabled_q || !out_valid_q || result_ready);
	assign event_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (event_ready) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_ready && event_valid) begin
			slot_s1 <= time_slot;
			ev_s1 <= '{hel: helicity, ps: pair_sync, ms: multiplet_sync,
			           pred_ok: helicity_predicted_ok};
		end
	end

	// window tracking and checks
	hwsc_tracker #(
		.SLOT_BITS(SLOT_BITS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.enable (check_enabled_q),
		.slot   (slot_s1),
		.ev     (ev_s1),
		.code   (code)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && check_enabled_q) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && check_enabled_q) begin
			out_code_q <= code;
		end
	end

	assign result_valid = out_valid_q;
	assign error_code = out_code_q;

endmodule

FILE: rtl/hwsc_checker.sv
// port-level assertions for the helicity window sequence checker, with its bind
// depends on assert_macros.svh and the top level's ports
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hwsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       event_valid,
	input logic       event_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [3:0] error_code
);

	// a pending result holds until taken
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(error_code))

	// codes stay within the defined set
	`ASSERT_IMPLY(a_code_range, clk, arst_n, result_valid, error_code <= 4'd10)

	// a fresh result comes from an accepted request held in the event stage
	`ASSERT_IMPLY(a_result_source, clk, arst_n, $rose(result_valid), $past(event_valid && event_ready, 2))

	// with the result register empty the event side never stalls
	`ASSERT_IMPLY(a_no_idle_stall, clk, arst_n, !result_valid, event_ready)

endmodule

bind helicity_window_sequence_checker hwsc_checker u_hwsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.event_valid  (event_valid),
	.event_ready  (event_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.error_code   (error_code)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench of the helicity window sequence checker: directed and random event streams
// depends on hwsc_pkg and helicity_window_sequence_checker; scoreboard class predicts error codes

module tb import hwsc_pkg::*;;

	// window tracking copy of the block, with the queue of codes still to come
	class window_scoreboard;
		bit                       enabled;
		logic [2:0]               pos;
		logic [SLOT_BITS_DEF-1:0] last_slot;
		logic                     cur_valid;
		win_bits_t                cur_bits;
		logic                     prev_valid;
		win_bits_t                prev_bits;
		err_code_t                expected_codes[$];
		int                       errors;

		function new();
			enabled = 1'b1;
			pos = POS_UNSYNC;
			last_slot = '0;
			cur_valid = 1'b0;
			cur_bits = '0;
			prev_valid = 1'b0;
			prev_bits = '0;
			errors = 0;
		endfunction

		// advance the window state by one accepted event; queue its code when checks are on
		function void note_event(logic [SLOT_BITS_DEF-1:0] slot, logic hel, logic ps,
				logic ms, logic pred_ok);
			logic      fresh;
			err_code_t code;
			fresh = (slot == 1) || (slot <= last_slot);
			code = ERR_OK;
			last_slot = slot;
			if (!enabled)
				return;

			// first event of a window: position, prediction, pair sync and previous window checks
			if (fresh) begin
				prev_valid = cur_valid;
				prev_bits = cur_bits;
				cur_valid = 1'b1;
				cur_bits.hel = hel;
				cur_bits.ps = ps;
				cur_bits.ms = ms;

				if (!ms && pos == POS_UNSYNC) begin
					pos = 3'd0;
				end else if (pos < POS_UNSYNC) begin
					pos = {1'b0, pos[1:0] + 2'd1};
					if (!ms && pos != 3'd0) begin
						code = ERR_UNEXP_FIRST;
						pos = 3'd0;
					end else if (ms && pos == 3'd0) begin
						code = ERR_UNEXP_OTHER;
					end
				end

				if (pos == 3'd0 && !pred_ok)
					code = ERR_HEL_WRONG;
				if (((pos == 3'd0 || pos == 3'd2) && ps) ||
						((pos == 3'd1 || pos == 3'd3) && !ps))
					code = ERR_PS_POS;

				if (prev_valid) begin
					if (ps == prev_bits.ps)
						code = ERR_PS_SAME;
					if (pos == 3'd1 || pos == 3'd3) begin
						if (hel == prev_bits.hel)
							code = ERR_HEL_SAME;
					end else if (pos == 3'd2) begin
						if (hel != prev_bits.hel)
							code = ERR_HEL_CHANGED;
					end
				end
			end

			// later events of a window must repeat the first event's bits
			if (!fresh && cur_valid) begin
				if (ps != cur_bits.ps)
					code = ERR_PS_MID;
				if (ms != cur_bits.ms)
					code = ERR_MS_MID;
				if (hel != cur_bits.hel)
					code = ERR_HEL_MID;
			end

			expected_codes.push_back(code);
		endfunction

		// compare one result with the oldest queued code
		function void check_result(err_code_t got);
			err_code_t want;
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual error_code %0d",
					$time, got);
				errors++;
				return;
			end
			want = expected_codes.pop_front();
			if (got !== want) begin
				$display("%0t: error_code mismatch, expected %0d, actual %0d",
					$time, want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_codes.size();
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     event_valid = 1'b0;
	logic                     event_ready;
	logic [SLOT_BITS_DEF-1:0] time_slot = '0;
	logic                     helicity = 1'b0;
	logic                     pair_sync = 1'b0;
	logic                     multiplet_sync = 1'b0;
	logic                     helicity_predicted_ok = 1'b0;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic [3:0]               error_code;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic                     check_enabled = 1'b1;

	window_scoreboard sb = new();
	int               n_sent = 0;
	bit               idle_on = 1'b1;
	bit               hold_req = 1'b0;

	helicity_window_sequence_checker #(
		.SLOT_BITS(SLOT_BITS_DEF)
	) dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.event_valid           (event_valid),
		.event_ready           (event_ready),
		.time_slot             (time_slot),
		.helicity              (helicity),
		.pair_sync             (pair_sync),
		.multiplet_sync        (multiplet_sync),
		.helicity_predicted_ok (helicity_predicted_ok),
		.result_valid          (result_valid),
		.result_ready          (result_ready),
		.error_code            (error_code),
		.cfg_valid             (cfg_valid),
		.cfg_ready             (cfg_ready),
		.check_enabled         (check_enabled)
	);

	// 8 ns clock
	always #4 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	// result checking at the rising edge
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(error_code);
	end

	// result side: random stall bursts and one long hold-off
	initial begin
		int stall;
		bit held;
		stall = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (150) @(negedge clk);
			end else begin
				if (stall == 0 && idle_on && $urandom_range(0, 7) == 0)
					stall = $urandom_range(1, 19);
				if (stall > 0) begin
					result_ready <= 1'b0;
					stall--;
				end else begin
					result_ready <= 1'b1;
				end
			end
		end
	end

	// offer one event request, with an optional idle burst ahead of it
	task automatic send_event(input logic [SLOT_BITS_DEF-1:0] slot, input logic hel,
			input logic ps, input logic ms, input logic ok);
		int gap;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			event_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		event_valid <= 1'b1;
		time_slot <= slot;
		helicity <= hel;
		pair_sync <= ps;
		multiplet_sync <= ms;
		helicity_predicted_ok <= ok;
		do @(posedge clk); while (!event_ready);
		sb.note_event(slot, hel, ps, ms, ok);
		n_sent++;
	endtask

	// fully random events
	task automatic send_noise(input int count);
		repeat (count)
			send_event(SLOT_BITS_DEF'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
	endtask

	// one window at multiplet position p with base helicity b, a few events rarely corrupted
	task automatic send_window(input int p, input bit b);
		int   n;
		int   i;
		int   nxt;
		int   r;
		logic [SLOT_BITS_DEF-1:0] slot;
		logic hel;
		logic ps;
		logic ms;
		logic ok;
		n = $urandom_range(1, 6);
		slot = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'd1;
		ok = ($urandom_range(0, 19) != 0);
		for (i = 0; i < n; i++) begin
			hel = (p == 1 || p == 2) ? ~b : b;
			ps = p[0];
			ms = (p != 0);
			r = $urandom_range(0, 29);
			if (r == 0)
				hel = ~hel;
			else if (r == 1)
				ps = ~ps;
			else if (r == 2)
				ms = ~ms;
			else if (r == 3)
				slot = SLOT_BITS_DEF'($urandom_range(0, 255));
			send_event(slot, hel, ps, ms, ok);
			nxt = slot + $urandom_range(1, 60);
			if (nxt > 255)
				break;
			slot = SLOT_BITS_DEF'(nxt);
		end
	endtask

	// well-formed multiplets with dropped windows and noise mixed in
	task automatic run_multiplets(input int n_items);
		int start;
		int p;
		bit b;
		start = n_sent;
		while (n_sent - start < n_items) begin
			b = $urandom_range(0, 1);
			for (p = 0; p < 4; p++) begin
				if ($urandom_range(0, 19) == 0)
					continue;
				send_window(p, b);
			end
			if ($urandom_range(0, 9) == 0)
				send_noise($urandom_range(1, 4));
		end
	endtask

	// stop offering, wait for all results, then let the pipeline drain
	task automatic settle();
		@(negedge clk);
		event_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// configuration write request
	task automatic write_enable(input logic en);
		@(negedge clk);
		cfg_valid <= 1'b1;
		check_enabled <= en;
		do @(posedge clk); while (!cfg_ready);
		sb.enabled = en;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hand-picked stream: every error code, the unsynchronised start, slot extremes
	task automatic run_directed();
		send_event(8'd3,   1'b0, 1'b1, 1'b1, 1'b1); // no window yet
		send_event(8'd1,   1'b1, 1'b1, 1'b1, 1'b1); // other window while unsynchronised
		send_event(8'd2,   1'b0, 1'b0, 1'b0, 1'b1); // all bits change mid window
		send_event(8'd1,   1'b0, 1'b0, 1'b0, 1'b1); // first window syncs
		send_event(8'd2,   1'b0, 1'b1, 1'b0, 1'b1); // pair sync change mid window
		send_event(8'd3,   1'b0, 1'b0, 1'b1, 1'b1); // multiplet sync change mid window
		send_event(8'd1,   1'b1, 1'b1, 1'b1, 1'b1);
		send_event(8'd1,   1'b1, 1'b0, 1'b1, 1'b1);
		send_event(8'd1,   1'b1, 1'b1, 1'b1, 1'b1); // helicity same at position 3
		send_event(8'd255, 1'b1, 1'b1, 1'b1, 1'b1);
		send_event(8'd0,   1'b0, 1'b0, 1'b0, 1'b0); // prediction fails
		send_event(8'd1,   1'b1, 1'b1, 1'b1, 1'b1);
		send_event(8'd1,   1'b0, 1'b0, 1'b0, 1'b1); // first window too early
		send_event(8'd1,   1'b1, 1'b1, 1'b1, 1'b1);
		send_event(8'd1,   1'b1, 1'b0, 1'b1, 1'b1);
		send_event(8'd1,   1'b0, 1'b1, 1'b1, 1'b1);
		send_event(8'd1,   1'b0, 1'b0, 1'b1, 1'b1); // other window where first expected
		send_event(8'd1,   1'b1, 1'b1, 1'b1, 1'b1);
		send_event(8'd1,   1'b0, 1'b1, 1'b1, 1'b1); // helicity changed at position 2
		send_event(8'd1,   1'b1, 1'b1, 1'b1, 1'b1); // pair sync same as previous
		send_event(8'd1,   1'b0, 1'b0, 1'b0, 1'b1);
		send_event(8'd1,   1'b1, 1'b0, 1'b1, 1'b1);
		send_event(8'd1,   1'b1, 1'b1, 1'b1, 1'b1); // pair sync against position
		send_event(8'd128, 1'b1, 1'b1, 1'b1, 1'b1);
	endtask

	// main sequence
	initial begin
		int k;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_enable(1'b1);
		run_directed();
		settle();

		// checks off: only the slot history moves
		write_enable(1'b0);
		send_noise(20);
		run_multiplets(10);
		settle();
		write_enable(1'b1);

		for (k = 0; k < 6; k++) begin
			idle_on = (k != 1 && k != 5);
			if (k == 2)
				hold_req = 1'b1;
			if (k == 3) begin
				settle();
				write_enable(1'b0);
				send_noise(30);
				settle();
				write_enable(1'b1);
			end
			run_multiplets(80);
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/hwsc_pkg.sv
rtl/hwsc_tracker.sv
rtl/helicity_window_sequence_checker.sv
rtl/hwsc_checker.sv
tb/sv/tb.sv
